### sv/edd_pkg.sv
`default_nettype none

package edd_pkg;

   localparam int LINE_MAX_DEF = 256;
   localparam int FRAME_MAX    = 4096;

   localparam int GRAY_W   = 8;
   localparam int WIDTH_W  = 9;
   localparam int HEIGHT_W = 13;
   localparam int ROW_W    = 12;
   localparam int ERR_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd2;

   localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST   = 9'd128;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd64;
   localparam logic [GRAY_W-1:0]   THRESHOLD_RST    = 8'd96;

   localparam logic [3:0] K_RIGHT      = 4'd7;
   localparam logic [3:0] K_BELOW_LEFT = 4'd3;
   localparam logic [3:0] K_BELOW      = 4'd5;
   localparam logic [3:0] K_BELOW_RIGHT = 4'd1;

   typedef logic signed [ERR_W-1:0] err_type;

   typedef struct packed {
      logic row_nz;
      logic last_col;
      logic last_row;
   } pos_type;

   typedef struct packed {
      logic    out_bit;
      err_type left_data;
      err_type below_left;
      err_type below;
      err_type right;
   } diffuse_type;

   // e*k/16, truncated toward zero
   function automatic err_type share(input err_type e, input logic [3:0] k);
      logic signed [13:0] prod;
      logic signed [13:0] adj;
      logic signed [13:0] quo;
      prod = 14'(e) * 14'($signed({1'b0, k}));
      adj  = prod + (prod[13] ? 14'sd15 : 14'sd0);
      quo  = adj >>> 4;
      return quo[ERR_W-1:0];
   endfunction

endpackage

`default_nettype wire

### sv/edd_ram.sv
`default_nettype none

module edd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/edd_raster.sv
`default_nettype none

module edd_raster #(
   parameter int LINE_MAX = 256,
   parameter int CW       = $clog2(LINE_MAX)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire logic [edd_pkg::WIDTH_W-1:0]     line_width,
   input  wire logic [edd_pkg::HEIGHT_W-1:0]    frame_height,
   output logic      [CW-1:0]                   col,
   output edd_pkg::pos_type                     pos
);

   import edd_pkg::*;

   localparam int WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [WW-1:0]       w_raw, w_eff, col_ext;
   logic [HEIGHT_W-1:0] h_eff, row_ext;
   logic                last_col, last_row;

   always_comb begin
      w_raw   = WW'(line_width);
      w_eff   = (w_raw == '0) ? WW'(1) :
                (w_raw > WW'(LINE_MAX)) ? WW'(LINE_MAX) : w_raw;
      col_ext = WW'(col_ff);
      h_eff   = (frame_height == '0) ? HEIGHT_W'(1) :
                (frame_height > HEIGHT_W'(FRAME_MAX)) ? HEIGHT_W'(FRAME_MAX) : frame_height;
      row_ext = HEIGHT_W'(row_ff);
      last_col = (col_ext + WW'(1) >= w_eff) || (col_ff == CW'(LINE_MAX - 1));
      last_row = (row_ext + HEIGHT_W'(1) >= h_eff);

      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col          = col_ff;
   assign pos.row_nz   = (row_ff != '0);
   assign pos.last_col = last_col;
   assign pos.last_row = last_row;

endmodule

`default_nettype wire

### sv/edd_diffuse.sv
`default_nettype none

module edd_diffuse (
   input  wire logic [edd_pkg::GRAY_W-1:0] gray,
   input  wire edd_pkg::err_type           above_err,
   input  wire edd_pkg::err_type           right_err,
   input  wire edd_pkg::err_type           below_left_pend,
   input  wire edd_pkg::err_type           below_pend,
   input  wire logic [edd_pkg::GRAY_W-1:0] threshold,
   input  wire logic                       last_col,
   output edd_pkg::diffuse_type            res
);

   import edd_pkg::*;

   logic signed [10:0] sum;
   logic [GRAY_W-1:0]  corr;
   logic               white;
   err_type            e;
   err_type            s_bl, s_b, s_br, s_r;

   always_comb begin
      sum = $signed({3'b000, gray})
          + $signed({{2{right_err[ERR_W-1]}}, right_err})
          + $signed({{2{above_err[ERR_W-1]}}, above_err});
      if (sum[10]) begin
         corr = '0;
      end else if (sum[9:8] != 2'b00) begin
         corr = 8'd255;
      end else begin
         corr = sum[7:0];
      end
      white = (corr > threshold);
      e     = $signed({1'b0, corr}) - (white ? 9'sd255 : 9'sd0);
      s_bl  = share(e, K_BELOW_LEFT);
      s_b   = share(e, K_BELOW);
      s_br  = share(e, K_BELOW_RIGHT);
      s_r   = share(e, K_RIGHT);

      res.out_bit    = white;
      res.left_data  = below_left_pend + s_bl;
      res.below_left = below_pend + s_b;
      res.below      = last_col ? '0 : s_br;
      res.right      = last_col ? '0 : s_r;
   end

endmodule

`default_nettype wire

### sv/error_diffusion_dither_1bit.sv
`default_nettype none

// flow: an accepted item is held in the sa stage registers while it is dithered,
//   then its result is registered into the rsp registers and offered on rsp
// throughput: one item per cycle unless rsp_ready holds the output; the line store read
//   and its write-back of the finished column share one ram port pair each cycle
// reset: synchronous; clears raster position, carried errors, line store valid
//   bits and handshake state, and loads the register defaults; no clearing pass

module error_diffusion_dither_1bit #(
   parameter int LINE_MAX = edd_pkg::LINE_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [edd_pkg::GRAY_W-1:0]        req_gray_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_out_bit,
   output logic                                   rsp_row_last,
   output logic                                   rsp_frame_last,
   input  wire logic                              csr_wr_en,
   input  wire logic [edd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [edd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import edd_pkg::*;

   localparam int CW = $clog2(LINE_MAX);

   logic [WIDTH_W-1:0]  line_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic [GRAY_W-1:0]   threshold_ff;

   logic          accept, advance;
   logic [CW-1:0] pos_col;
   pos_type       pos;

   logic              sa_vld_ff, sa_vld_in;
   logic [GRAY_W-1:0] sa_gray_ff;
   logic [CW-1:0]     sa_col_ff, sa_col_in;
   pos_type           sa_pos_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_out_bit_ff, rsp_row_last_ff, rsp_frame_last_ff;

   err_type right_ff, bl_ff, b_ff;

   logic          p_vld_ff, p_vld_in, p_cap;
   logic [CW-1:0] p_addr_ff;
   err_type       p_data_ff;

   logic    byp_vld_ff, byp_vld_in;
   err_type byp_data_ff;

   logic [LINE_MAX-1:0] valid_ff, valid_in;

   logic          a_en;
   logic [CW-1:0] a_addr;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   err_type       wr_data;
   logic [ERR_W-1:0] ram_rd;
   err_type       stored, above_err;
   diffuse_type   dres;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         threshold_ff    <= THRESHOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_THRESHOLD:    threshold_ff    <= csr_wdata[GRAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = sa_vld_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~sa_vld_ff | advance;
   assign accept    = req_valid & req_ready;

   edd_raster #(
      .LINE_MAX (LINE_MAX)
   ) u_raster (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .col          (pos_col),
      .pos          (pos)
   );

   // line store write port: left column write-back, or the pending last-column write
   always_comb begin
      a_en    = advance && (sa_col_ff != '0);
      a_addr  = sa_col_ff - CW'(1);
      p_cap   = advance && sa_pos_ff.last_col;
      wr_en   = a_en | p_vld_ff;
      wr_addr = a_en ? a_addr : p_addr_ff;
      wr_data = a_en ? dres.left_data : p_data_ff;
      if (p_cap) begin
         p_vld_in = 1'b1;
      end else if (!a_en) begin
         p_vld_in = 1'b0;
      end else begin
         p_vld_in = p_vld_ff;
      end

      for (int i = 0; i < LINE_MAX; i++) begin
         valid_in[i] = valid_ff[i] | (a_en && (a_addr == CW'(i)))
                                   | (p_cap && (sa_col_ff == CW'(i)));
      end

      sa_vld_in  = accept | (sa_vld_ff & ~advance);
      sa_col_in  = accept ? pos_col : sa_col_ff;
      byp_vld_in = wr_en && (wr_addr == sa_col_in);
   end

   edd_ram #(
      .WIDTH (ERR_W),
      .DEPTH (LINE_MAX)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (sa_col_in),
      .rd_data (ram_rd)
   );

   // newest copy of the entry for this column
   always_comb begin
      if (p_vld_ff && (p_addr_ff == sa_col_ff)) begin
         stored = p_data_ff;
      end else if (byp_vld_ff) begin
         stored = byp_data_ff;
      end else begin
         stored = $signed(ram_rd);
      end
      above_err = (sa_pos_ff.row_nz && valid_ff[sa_col_ff]) ? stored : '0;
   end

   edd_diffuse u_diffuse (
      .gray            (sa_gray_ff),
      .above_err       (above_err),
      .right_err       (right_ff),
      .below_left_pend (bl_ff),
      .below_pend      (b_ff),
      .threshold       (threshold_ff),
      .last_col        (sa_pos_ff.last_col),
      .res             (dres)
   );

   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p_vld_ff     <= 1'b0;
         byp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         right_ff     <= '0;
         bl_ff        <= '0;
         b_ff         <= '0;
      end else begin
         sa_vld_ff    <= sa_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         p_vld_ff     <= p_vld_in;
         byp_vld_ff   <= byp_vld_in;
         valid_ff     <= valid_in;
         if (advance) begin
            right_ff <= dres.right;
            bl_ff    <= sa_pos_ff.last_col ? '0 : dres.below_left;
            b_ff     <= dres.below;
         end
      end
   end

   always_ff @(posedge clock) begin
      sa_col_ff   <= sa_col_in;
      byp_data_ff <= wr_data;
      if (accept) begin
         sa_gray_ff <= req_gray_value;
         sa_pos_ff  <= pos;
      end
      if (p_cap) begin
         p_addr_ff <= sa_col_ff;
         p_data_ff <= dres.below_left;
      end
      if (advance) begin
         rsp_out_bit_ff    <= dres.out_bit;
         rsp_row_last_ff   <= sa_pos_ff.last_col;
         rsp_frame_last_ff <= sa_pos_ff.last_col & sa_pos_ff.last_row;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bit    = rsp_out_bit_ff;
   assign rsp_row_last   = rsp_row_last_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   a_single_write : assert property (@(posedge clock) disable iff (reset)
      !(p_vld_ff && a_en))
      else $error("pending last-column write collides with left write-back");

   a_pending_set : assert property (@(posedge clock) disable iff (reset)
      p_cap |=> p_vld_ff)
      else $error("last-column write not held pending");

   a_pending_flush : assert property (@(posedge clock) disable iff (reset)
      (p_vld_ff && !p_cap) |=> !p_vld_ff)
      else $error("pending write not flushed within one cycle");

   a_row_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && pos.last_col) |=> (pos_col == '0))
      else $error("column count did not wrap after last column");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import edd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RUN_LIMIT = 400000;
   localparam int LONG_HOLD = 300;
   localparam int END_WAIT  = 8;

   typedef struct packed {
      logic out_bit;
      logic row_last;
      logic frame_last;
   } pix_result_type;

   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [GRAY_W-1:0]     gray;
      bit                    typed;
      pix_result_type        want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [GRAY_W-1:0]     req_gray_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_out_bit;
   logic                  rsp_row_last;
   logic                  rsp_frame_last;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // dither model state
   int mdl_width  = LINE_WIDTH_RST;
   int mdl_height = FRAME_HEIGHT_RST;
   int mdl_thresh = THRESHOLD_RST;
   int err_row [LINE_MAX_DEF];
   int carry_right, pend_left, pend_here;
   int col_pos, row_pos;

   pix_result_type pending_pixels [$];
   int fail_count, rsp_count, pix_sent, cycle_count;

   // directed items; typed expectations where the result is obvious
   plan_row_type plan [33] = '{
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd0,   1'b1, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd255, 1'b1, 3'b100},
      '{1'b1, CSR_LINE_WIDTH,   13'd0,      8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd200, 1'b1, 3'b110},
      '{1'b1, CSR_FRAME_HEIGHT, 13'd0,      8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd50,  1'b1, 3'b011},
      '{1'b1, CSR_THRESHOLD,    13'd255,    8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd255, 1'b1, 3'b011},
      '{1'b1, CSR_THRESHOLD,    13'd0,      8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd0,   1'b1, 3'b011},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd1,   1'b1, 3'b111},
      '{1'b1, CSR_UNUSED,       13'h1fff,   8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd1,   1'b1, 3'b111},
      '{1'b1, CSR_LINE_WIDTH,   13'h1fff,   8'd0,   1'b0, 3'b000},
      '{1'b1, CSR_FRAME_HEIGHT, 13'h1fff,   8'd0,   1'b0, 3'b000},
      '{1'b1, CSR_THRESHOLD,    13'h1f80,   8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd255, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd128, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd129, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd127, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd64,  1'b0, 3'b000},
      '{1'b1, CSR_LINE_WIDTH,   13'd2,      8'd0,   1'b0, 3'b000},
      '{1'b1, CSR_FRAME_HEIGHT, 13'd2,      8'd0,   1'b0, 3'b000},
      '{1'b1, CSR_THRESHOLD,    13'd96,     8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd255, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd0,   1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd200, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd10,  1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd100, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd90,  1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd255, 1'b0, 3'b000},
      '{1'b0, CSR_LINE_WIDTH,   13'd0,      8'd255, 1'b0, 3'b000}
   };

   error_diffusion_dither_1bit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_gray_value (req_gray_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bit    (rsp_out_bit),
      .rsp_row_last   (rsp_row_last),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // share of the error, truncated toward zero
   function automatic int err_part(input int e, input int k);
      return (e * k) / 16;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pix_result_type dither_pixel(input logic [GRAY_W-1:0] g);
      int w, h, sum, q, e;
      bit at_row_end, at_frame_row;
      pix_result_type res;
      w = (mdl_width == 0) ? 1 : (mdl_width > LINE_MAX_DEF) ? LINE_MAX_DEF : mdl_width;
      h = (mdl_height == 0) ? 1 : (mdl_height > FRAME_MAX) ? FRAME_MAX : mdl_height;
      at_row_end = (col_pos + 1 >= w) || (col_pos >= LINE_MAX_DEF - 1);
      at_frame_row = (row_pos + 1 >= h);
      sum = int'(g) + carry_right;
      if (row_pos != 0) sum += err_row[col_pos];
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      q = (sum <= mdl_thresh) ? 0 : 255;
      e = sum - q;
      if (col_pos > 0) err_row[col_pos - 1] = pend_left + err_part(e, K_BELOW_LEFT);
      pend_left = pend_here + err_part(e, K_BELOW);
      pend_here = at_row_end ? 0 : err_part(e, K_BELOW_RIGHT);
      carry_right = at_row_end ? 0 : err_part(e, K_RIGHT);
      if (at_row_end) begin
         err_row[col_pos] = pend_left;
         pend_left = 0;
         pend_here = 0;
         col_pos = 0;
         row_pos = at_frame_row ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      res.out_bit = (q != 0);
      res.row_last = at_row_end;
      res.frame_last = at_row_end && at_frame_row;
      return res;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_LINE_WIDTH:   mdl_width = data[WIDTH_W-1:0];
         CSR_FRAME_HEIGHT: mdl_height = data;
         CSR_THRESHOLD:    mdl_thresh = data[GRAY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_pixel(input logic [GRAY_W-1:0] g, input bit burst,
                             input bit typed, input pix_result_type want);
      int gap;
      pix_result_type res;
      gap = burst ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_gray_value <= g;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = dither_pixel(g);
      pending_pixels.push_back(typed ? want : res);
      pix_sent++;
      @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin : check_rsp
      pix_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_pixels.size() == 0) begin
            $error("unexpected item: out_bit %0b row_last %0b frame_last %0b",
                   rsp_out_bit, rsp_row_last, rsp_frame_last);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_bit !== want.out_bit) begin
               $error("out_bit: expected %0b, got %0b", want.out_bit, rsp_out_bit);
               fail_count++;
            end
            if (rsp_row_last !== want.row_last) begin
               $error("row_last: expected %0b, got %0b", want.row_last, rsp_row_last);
               fail_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last,
                      rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random back-pressure, two long holds to fill the pipe
   initial begin : drive_rsp_ready
      int stall_left, ready_left, holds;
      stall_left = 0;
      ready_left = 0;
      holds = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds < 2 && rsp_count >= 150 + 350 * holds) begin
            holds++;
            stall_left = LONG_HOLD;
            ready_left = 0;
         end
         if (stall_left == 0 && ready_left == 0) begin
            stall_left = gap_len();
            ready_left = $urandom_range(1, 40);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            ready_left--;
         end
      end
   end

   initial begin : stimulus
      int phase, n, r, g, level, v;
      bit burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_gray_value = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_LINE_WIDTH;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_pixel(plan[i].gray, 1'b0, plan[i].typed, plan[i].want);
         end
      end

      phase = 0;
      while (pix_sent < 830) begin
         if (phase == 0) begin
            // full-width rows reach the last store column
            write_reg(CSR_LINE_WIDTH, 13'd256);
            write_reg(CSR_FRAME_HEIGHT, 13'd2);
            write_reg(CSR_THRESHOLD, 13'($urandom_range(0, 255)));
            n = 300;
         end else begin
            if ($urandom_range(0, 9) < 7) begin
               r = $urandom_range(0, 99);
               if (r < 60) v = $urandom_range(1, 12);
               else if (r < 70) v = $urandom_range(13, 64);
               else if (r < 78) v = 0;
               else if (r < 84) v = 256;
               else if (r < 90) v = $urandom_range(257, 511);
               else v = 1;
               write_reg(CSR_LINE_WIDTH, {4'($urandom_range(0, 15)), 9'(v)});
            end
            if ($urandom_range(0, 9) < 7) begin
               r = $urandom_range(0, 99);
               if (r < 50) v = $urandom_range(1, 6);
               else if (r < 65) v = $urandom_range(7, 40);
               else if (r < 75) v = 0;
               else if (r < 82) v = 4096;
               else if (r < 90) v = $urandom_range(4097, 8191);
               else v = 1;
               write_reg(CSR_FRAME_HEIGHT, 13'(v));
            end
            if ($urandom_range(0, 9) < 7) begin
               r = $urandom_range(0, 9);
               v = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
               write_reg(CSR_THRESHOLD, {5'($urandom_range(0, 31)), 8'(v)});
            end
            if ($urandom_range(0, 9) == 0)
               write_reg(CSR_UNUSED, 13'($urandom_range(0, 8191)));
            n = $urandom_range(10, 90);
         end
         burst = ($urandom_range(0, 3) == 0);
         level = $urandom_range(0, 255);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 8) g = 0;
            else if (r < 16) g = 255;
            else if (r < 36) g = mdl_thresh + int'($urandom_range(0, 6)) - 3;
            else if (r < 60) g = level + int'($urandom_range(0, 8)) - 4;
            else g = $urandom_range(0, 255);
            if (g < 0) g = 0;
            if (g > 255) g = 255;
            send_pixel(8'(g), burst, 1'b0, '0);
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (END_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
sv/edd_pkg.sv
sv/edd_ram.sv
sv/edd_raster.sv
sv/edd_diffuse.sv
sv/error_diffusion_dither_1bit.sv
sim/tb.sv
